// ----- src/dataset_mean_median_mode_assert.svh -----
// assertion macros for the dataset mean, median and mode block
// used by the checker, which supplies clock and reset in its own scope
`ifndef DATASET_MEAN_MEDIAN_MODE_ASSERT_SVH
`define DATASET_MEAN_MEDIAN_MODE_ASSERT_SVH

// same-cycle implication, off during reset
`define DMMM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define DMMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/dmmm_pkg.sv -----
// shared widths, codes and cell control type for the mean, median and mode block
// no dependencies
package dmmm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 22;
   localparam int CNT_W      = 6;
   localparam int VALUE_W    = 24;
   localparam int KIND_W     = 2;
   localparam int FRAC_W     = 8;
   localparam int DIVIDEND_W = SUM_W + FRAC_W;
   localparam int STEP_W     = $clog2(DIVIDEND_W);

   // result kinds as carried on the result channel
   typedef enum logic [KIND_W-1:0] {
      KIND_MEAN   = 2'd0,
      KIND_MEDIAN = 2'd1,
      KIND_MODE   = 2'd2
   } kind_type;

   // what the cell row does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_ROTATE = 2'd2
   } cell_op_type;

   // broadcast to every cell
   typedef struct packed {
      cell_op_type               op;
      logic [SAMPLE_W-1:0]       sample;
      logic [CNT_W-1:0]          count;
   } cell_ctl_type;

endpackage

// ----- src/dmmm_cell.sv -----
// one cell of the sorted sample row: holds one sample, inserts or rotates
// depends on dmmm_pkg
module dmmm_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                                 clock,
   input  dmmm_pkg::cell_ctl_type               ctl,
   input  logic signed [dmmm_pkg::SAMPLE_W-1:0] left_value,
   input  logic signed [dmmm_pkg::SAMPLE_W-1:0] right_value,
   input  logic signed [dmmm_pkg::SAMPLE_W-1:0] head_value,
   output logic signed [dmmm_pkg::SAMPLE_W-1:0] value
);
   import dmmm_pkg::*;

   localparam logic [CNT_W-1:0] MY_INDEX   = CNT_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0] NEXT_INDEX = CNT_W'(CELL_INDEX + 1);

   logic signed [SAMPLE_W-1:0] value_ff, value_in;
   logic signed [SAMPLE_W-1:0] sample_s;
   logic                       own_gt, left_gt;

   // insert shifts larger entries up by one, rotate moves the row toward cell 0
   always_comb begin
      sample_s = ctl.sample;
      own_gt   = value_ff > sample_s;
      left_gt  = (CELL_INDEX != 0) && (left_value > sample_s);
      value_in = value_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (MY_INDEX < ctl.count) begin
               if (own_gt) begin
                  value_in = left_gt ? left_value : sample_s;
               end
            end else if (MY_INDEX == ctl.count) begin
               value_in = left_gt ? left_value : sample_s;
            end
         end
         CELL_ROTATE: begin
            if (NEXT_INDEX == ctl.count) begin
               value_in = head_value;
            end else if (NEXT_INDEX < ctl.count) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ----- src/dmmm_div.sv -----
// radix-2 restoring divider for the mean: (sum * 256) / count, truncated toward zero
// depends on dmmm_pkg
module dmmm_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [dmmm_pkg::SUM_W-1:0]   sum,
   input  logic [dmmm_pkg::CNT_W-1:0]          count,
   output logic                                done,
   output logic [dmmm_pkg::VALUE_W-1:0]        quotient
);
   import dmmm_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [DIVIDEND_W-1:0]   dividend_ff, dividend_in;
   logic [DIVIDEND_W-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        divisor_ff, divisor_in;
   logic                    neg_ff, neg_in;
   logic [SUM_W-1:0]        magnitude;
   logic [CNT_W:0]          trial;
   logic                    fits;
   logic [DIVIDEND_W-1:0]   signed_quot;

   // one quotient bit per cycle, sign applied at the end
   always_comb begin
      busy_in     = busy_ff;
      done_in     = done_ff;
      step_in     = step_ff;
      dividend_in = dividend_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      neg_in      = neg_ff;
      magnitude   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      trial       = {rem_ff, dividend_ff[DIVIDEND_W-1]};
      fits        = trial >= {1'b0, divisor_ff};
      if (start) begin
         busy_in     = 1'b1;
         done_in     = 1'b0;
         step_in     = '0;
         dividend_in = {magnitude, {FRAC_W{1'b0}}};
         quot_in     = '0;
         rem_in      = '0;
         divisor_in  = count;
         neg_in      = sum[SUM_W-1];
      end else if (busy_ff) begin
         rem_in      = fits ? CNT_W'(trial - {1'b0, divisor_ff}) : trial[CNT_W-1:0];
         quot_in     = {quot_ff[DIVIDEND_W-2:0], fits};
         dividend_in = {dividend_ff[DIVIDEND_W-2:0], 1'b0};
         step_in     = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dividend_ff <= dividend_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      neg_ff      <= neg_in;
   end

   assign signed_quot = neg_ff ? (~quot_ff + 1'b1) : quot_ff;
   assign quotient    = signed_quot[VALUE_W-1:0];
   assign done        = done_ff;

endmodule

// ----- src/dataset_mean_median_mode.sv -----
// Dataset mean, median and mode over a sorted row of cells, one sample per cycle while idle.
// After the marked sample the input closes and the row rotates once for run lengths and median
// while a 30-step divider forms the mean: the mean goes out once both are done, the median
// from ST_MEDIAN after it, then a second rotation gives the modes in order.
// Reset is synchronous: clears count, sum and control; cell contents are kept.
module dataset_mean_median_mode #(
   parameter int MAX_SAMPLES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: sample_value [15:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dmmm_pkg::SAMPLE_W-1:0]       req_tdata,
   input  logic                                req_tlast,
   // rsp_tdata: result_value [23:0]; rsp_tuser: result_kind [1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dmmm_pkg::VALUE_W-1:0]        rsp_tdata,
   output logic [dmmm_pkg::KIND_W-1:0]         rsp_tuser,
   output logic                                rsp_tlast
);
   import dmmm_pkg::*;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SAMPLES);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PASS1  = 5'b00010,
      ST_MEAN   = 5'b00100,
      ST_MEDIAN = 5'b01000,
      ST_PASS2  = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]           run_ff, run_in;
   logic [CNT_W-1:0]           best_ff, best_in;
   logic [CNT_W-1:0]           nmodes_ff, nmodes_in;
   logic [CNT_W-1:0]           seen_ff, seen_in;
   logic signed [SAMPLE_W-1:0] med_lo_ff, med_lo_in;
   logic signed [SAMPLE_W-1:0] med_hi_ff, med_hi_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   kind_type                   rsp_kind_ff, rsp_kind_in;
   logic [VALUE_W-1:0]         rsp_value_ff, rsp_value_in;
   logic                       rsp_last_ff, rsp_last_in;

   cell_ctl_type               cell_ctl;
   logic signed [SAMPLE_W-1:0] cell_value [MAX_SAMPLES];
   logic signed [SAMPLE_W-1:0] head_value, second_value, sample_s;
   logic                       accept, out_free, last_idx, run_end;
   logic [CNT_W-1:0]           run_cur, mid;
   logic [SAMPLE_W:0]          med_pair;
   logic [VALUE_W-1:0]         median_value;
   logic                       div_start, div_done;
   logic [VALUE_W-1:0]         div_quotient;

   // sorted row of cells
   for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
      logic signed [SAMPLE_W-1:0] left_v, right_v;
      if (g == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_inner_left
         assign left_v = cell_value[g-1];
      end
      if (g == MAX_SAMPLES - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_inner_right
         assign right_v = cell_value[g+1];
      end
      dmmm_cell #(.CELL_INDEX(g)) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (head_value),
         .value       (cell_value[g])
      );
   end

   assign head_value = cell_value[0];
   if (MAX_SAMPLES > 1) begin : g_second
      assign second_value = cell_value[1];
   end else begin : g_single
      assign second_value = cell_value[0];
   end

   // mean divider
   dmmm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (sum_in),
      .count    (count_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // handshake and run tracking terms
   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign sample_s     = req_tdata;
   assign last_idx     = (idx_ff == count_ff - 1'b1);
   assign run_end      = last_idx || (head_value != second_value);
   assign run_cur      = run_ff + 1'b1;
   assign mid          = count_ff >> 1;
   assign med_pair     = {med_lo_ff[SAMPLE_W-1], med_lo_ff} + {med_hi_ff[SAMPLE_W-1], med_hi_ff};
   assign median_value = count_ff[0] ? {med_hi_ff, {FRAC_W{1'b0}}}
                                     : {med_pair, {(FRAC_W-1){1'b0}}};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      run_in       = run_ff;
      best_in      = best_ff;
      nmodes_in    = nmodes_ff;
      seen_in      = seen_ff;
      med_lo_in    = med_lo_ff;
      med_hi_in    = med_hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      div_start    = 1'b0;
      cell_ctl.op     = CELL_HOLD;
      cell_ctl.sample = req_tdata;
      cell_ctl.count  = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_ff < MAX_COUNT) begin
                  cell_ctl.op = CELL_INSERT;
                  count_in    = count_ff + 1'b1;
                  sum_in      = sum_ff + SUM_W'(sample_s);
               end
               if (req_tlast) begin
                  state_in  = ST_PASS1;
                  idx_in    = '0;
                  run_in    = '0;
                  best_in   = '0;
                  nmodes_in = '0;
                  div_start = 1'b1;
               end
            end
         end
         ST_PASS1: begin
            // first rotation: longest run, mode count, median samples
            cell_ctl.op = CELL_ROTATE;
            idx_in      = idx_ff + 1'b1;
            if (run_end) begin
               run_in = '0;
               if (run_cur > best_ff) begin
                  best_in   = run_cur;
                  nmodes_in = CNT_W'(1);
               end else if (run_cur == best_ff) begin
                  nmodes_in = nmodes_ff + 1'b1;
               end
            end else begin
               run_in = run_cur;
            end
            if ((mid != '0) && (idx_ff == mid - 1'b1)) begin
               med_lo_in = head_value;
            end
            if (idx_ff == mid) begin
               med_hi_in = head_value;
            end
            if (last_idx) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (div_done && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_MEAN;
               rsp_value_in = div_quotient;
               rsp_last_in  = 1'b0;
               state_in     = ST_MEDIAN;
            end
         end
         ST_MEDIAN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_MEDIAN;
               rsp_value_in = median_value;
               rsp_last_in  = 1'b0;
               state_in     = ST_PASS2;
               idx_in       = '0;
               run_in       = '0;
               seen_in      = '0;
            end
         end
         ST_PASS2: begin
            // second rotation: one step per free output slot, modes in order
            if (out_free) begin
               cell_ctl.op = CELL_ROTATE;
               idx_in      = idx_ff + 1'b1;
               if (run_end) begin
                  run_in = '0;
                  if (run_cur == best_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_MODE;
                     rsp_value_in = {head_value, {FRAC_W{1'b0}}};
                     rsp_last_in  = (seen_ff + 1'b1 == nmodes_ff);
                     seen_in      = seen_ff + 1'b1;
                  end
               end else begin
                  run_in = run_cur;
               end
               if (last_idx) begin
                  state_in = ST_IDLE;
                  count_in = '0;
                  sum_in   = '0;
                  best_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      run_ff       <= run_in;
      nmodes_ff    <= nmodes_in;
      seen_ff      <= seen_in;
      med_lo_ff    <= med_lo_in;
      med_hi_ff    <= med_hi_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/dmmm_checker.sv -----
// port-level checks for the mean, median and mode block, bound to the top level
// depends on dmmm_pkg and dataset_mean_median_mode_assert.svh
`include "dataset_mean_median_mode_assert.svh"

module dmmm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          req_tlast,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [dmmm_pkg::VALUE_W-1:0]  rsp_tdata,
   input logic [dmmm_pkg::KIND_W-1:0]   rsp_tuser,
   input logic                          rsp_tlast
);
   import dmmm_pkg::*;

   logic stalled, last_in, mode_out;

   assign stalled  = rsp_tvalid && !rsp_tready;
   assign last_in  = req_tvalid && req_tready && req_tlast;
   assign mode_out = rsp_tvalid && (rsp_tuser == KIND_MODE);

   // a stalled result holds
   `DMMM_ASSERT_NEXT(a_rsp_hold, stalled, rsp_tvalid && $stable(rsp_tdata), "result changed")
   // no sample taken right after the marked sample
   `DMMM_ASSERT_NEXT(a_busy_after_last, last_in, !req_tready, "input open after last")
   // only a mode closes the result set
   `DMMM_ASSERT_NOW(a_last_is_mode, rsp_tvalid && rsp_tlast, rsp_tuser == KIND_MODE, "bad last")
   // a mode is a whole sample in Q8
   `DMMM_ASSERT_NOW(a_mode_whole, mode_out, rsp_tdata[FRAC_W-1:0] == '0, "mode has fraction")

endmodule

bind dataset_mean_median_mode dmmm_checker u_dmmm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- test/dataset_mean_median_mode_tb.sv -----
// testbench for dataset_mean_median_mode: streams sample sets, predicts mean, median
// and modes of each set, and checks every result transfer; needs dmmm_pkg and the rtl
`timescale 1ns / 100ps

module dataset_mean_median_mode_tb;
   import dmmm_pkg::*;

   localparam int STORE_DEPTH    = 32;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int HOLD_OFF       = 400;

   typedef struct packed {
      kind_type               kind;
      logic [VALUE_W-1:0]     value;
      logic                   last;
   } stat_result_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [VALUE_W-1:0]    rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   // predictor state for the set being collected
   int                    sorted_vals[$];
   int                    set_sum;
   int                    set_count;
   stat_result_type       pending_stats[$];

   int                    send_idle_pct;
   int                    rsp_stall_pct;
   int                    hold_request;
   int                    hold_left;
   int                    idle_cycles;
   int                    error_count;
   int                    samples_sent;
   int                    sets_sent;
   int                    results_checked;

   dataset_mean_median_mode #(
      .MAX_SAMPLES(STORE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 8 ns clock, first rising edge at 4 ns
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // append one predicted result
   task automatic queue_stat(input stat_result_type res);
      pending_stats.insert(pending_stats.size(), res);
   endtask

   // insert one accepted sample; on the marked one, queue mean, median and modes
   task automatic predict_dataset_stats(input logic [SAMPLE_W-1:0] raw, input logic eos);
      int sample;
      int pos;
      int n;
      int mid;
      int run;
      int best_run;
      int mode_total;
      int modes_seen;
      stat_result_type res;
      sample = int'($signed(raw));
      if (set_count < STORE_DEPTH) begin
         pos = 0;
         while (pos < sorted_vals.size() && sorted_vals[pos] <= sample) pos++;
         sorted_vals.insert(pos, sample);
         set_sum += sample;
         set_count++;
      end
      if (!eos) return;
      n = set_count;

      // mean, truncated toward zero
      res.kind  = KIND_MEAN;
      res.value = VALUE_W'((set_sum * 256) / n);
      res.last  = 1'b0;
      queue_stat(res);

      // median, exact half for even counts
      mid = n / 2;
      res.kind = KIND_MEDIAN;
      if (n % 2 == 1) begin
         res.value = VALUE_W'(sorted_vals[mid] * 256);
      end else begin
         res.value = VALUE_W'((sorted_vals[mid] + sorted_vals[mid - 1]) * 128);
      end
      queue_stat(res);

      // longest run and how many runs reach it
      best_run   = 0;
      mode_total = 0;
      run        = 1;
      for (int i = 1; i <= n; i++) begin
         if (i < n && sorted_vals[i] == sorted_vals[i - 1]) begin
            run++;
         end else begin
            if (run > best_run) begin
               best_run   = run;
               mode_total = 1;
            end else if (run == best_run) begin
               mode_total++;
            end
            run = 1;
         end
      end

      // modes in ascending order, last one marked
      modes_seen = 0;
      run        = 1;
      res.kind   = KIND_MODE;
      for (int i = 1; i <= n; i++) begin
         if (i < n && sorted_vals[i] == sorted_vals[i - 1]) begin
            run++;
         end else begin
            if (run == best_run) begin
               modes_seen++;
               res.value = VALUE_W'(sorted_vals[i - 1] * 256);
               res.last  = (modes_seen == mode_total);
               queue_stat(res);
            end
            run = 1;
         end
      end

      sorted_vals.delete();
      set_sum   = 0;
      set_count = 0;
   endtask

   // offer one sample, with random gaps ahead of it, until the block takes it
   task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input logic eos);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      predict_dataset_stats(raw, eos);
      samples_sent++;
      if (eos) sets_sent++;
   endtask

   // receiver: random stalls, long hold-off on request, and result checking
   always @(posedge clock) begin
      stat_result_type want;
      if (hold_request > 0) begin
         hold_left    <= hold_request;
         hold_request = 0;
         rsp_tready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end

      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (pending_stats.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d value %h last %b",
                                      rsp_tuser, rsp_tdata, rsp_tlast));
         end else begin
            want = pending_stats.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata !== want.value ||
                rsp_tlast !== want.last) begin
               report_mismatch($sformatf(
                  "result got kind %0d value %h last %b, want kind %0d value %h last %b",
                  rsp_tuser, rsp_tdata, rsp_tlast, want.kind, want.value, want.last));
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                  idle_cycles, pending_stats.size());
         $display("** dataset_mean_median_mode: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample(input int style, input int center);
      case (style)
         0: pick_sample = SAMPLE_W'(int'($urandom_range(8)) - 4);
         1: pick_sample = SAMPLE_W'(center + int'($urandom_range(16)) - 8);
         2: pick_sample = SAMPLE_W'($urandom);
         default: begin
            case ($urandom_range(3))
               0: pick_sample = 16'h8000;
               1: pick_sample = 16'h7FFF;
               2: pick_sample = 16'hFFFF;
               default: pick_sample = 16'h0000;
            endcase
         end
      endcase
   endfunction

   // single-sample sets at both ends of the sample range and at zero
   task automatic test_single_extremes();
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h0000, 1'b1);
   endtask

   // even counts: median halfway between the middle pair, ties among modes
   task automatic test_even_median_and_modes();
      send_sample(16'd5, 1'b0);
      send_sample(-16'sd3, 1'b0);
      send_sample(16'd5, 1'b0);
      send_sample(16'd7, 1'b1);
      send_sample(16'd2, 1'b0);
      send_sample(16'd1, 1'b1);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h7FFE, 1'b1);
   endtask

   // mean rounding toward zero on both signs
   task automatic test_mean_truncation();
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0000, 1'b1);
      send_sample(16'h0001, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h0000, 1'b1);
   endtask

   // full store: every value distinct, marked sample arrives past the end and is dropped
   task automatic test_store_full();
      for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
         send_sample(SAMPLE_W'(i * 2053 - 32000), 1'b0);
      end
      send_sample(16'h7FFF, 1'b1);
   endtask

   // random sets, mostly small, with repeated values to form runs
   task automatic test_random_sets(input int item_budget, input int idle_pct,
                                   input int stall_pct);
      int sent;
      int size;
      int roll;
      int style;
      int center;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < item_budget) begin
         roll = $urandom_range(99);
         if (roll < 65) size = $urandom_range(10, 1);
         else if (roll < 90) size = $urandom_range(32, 11);
         else size = $urandom_range(40, 33);
         style  = $urandom_range(3);
         center = $urandom;
         for (int k = 0; k < size; k++) begin
            send_sample(pick_sample(style, center), k == size - 1);
         end
         sent += size;
      end
   endtask

   // receiver holds off for a long stretch while sets keep coming
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = HOLD_OFF;
      for (int s = 0; s < 4; s++) begin
         for (int k = 0; k < 4; k++) begin
            send_sample(pick_sample(0, 0), k == 3);
         end
      end
   endtask

   initial begin
      sorted_vals.delete();
      set_sum         = 0;
      set_count       = 0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      hold_request    = 0;
      hold_left       = 0;
      idle_cycles     = 0;
      error_count     = 0;
      samples_sent    = 0;
      sets_sent       = 0;
      results_checked = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_extremes();
      test_even_median_and_modes();
      test_mean_truncation();
      test_store_full();
      test_random_sets(72, 0, 0);
      test_random_sets(72, 45, 0);
      test_random_sets(72, 0, 45);
      test_random_sets(72, 11, 11);
      test_output_backpressure();
      req_tvalid <= 1'b0;

      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d samples in %0d sets, %0d results checked", samples_sent,
               sets_sent, results_checked);
      $display("including full-store drops, tied modes and a long output hold-off");
      if (error_count == 0) begin
         $display("** dataset_mean_median_mode: PASSED **");
      end else begin
         $display("** dataset_mean_median_mode: FAILED **");
      end
      $finish;
   end

endmodule
